// ----- design/cab64_pkg.sv -----
// ----------------------------------------------------------------------------
// cab64_pkg
// Shared types, constants and functions of the checksummed address encoder.
// ----------------------------------------------------------------------------
package cab64_pkg;

  localparam int unsigned AddrBytes = 32;
  localparam int unsigned IdxW      = $clog2(AddrBytes);
  localparam logic [IdxW-1:0] FirstIdx = '0;
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(AddrBytes - 1);

  localparam logic [7:0]  TagBounce = 8'd17;
  localparam logic [7:0]  TagPlain  = 8'd81;
  localparam logic [15:0] CrcPoly   = 16'h1021;
  localparam logic [15:0] CrcInit   = 16'h0000;

  localparam logic [1:0] PendFull  = 2'd2;
  localparam logic [1:0] SextLast  = 2'd3;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [6:0] CharMinus = 7'h2d;
  localparam logic [6:0] CharUnder = 7'h5f;
  localparam logic [6:0] CharUpA   = 7'h41;
  localparam logic [6:0] CharLowA  = 7'h61;
  localparam logic [6:0] CharZero  = 7'h30;

  // three frame bytes, oldest in the top byte
  typedef struct packed {
    logic [23:0] word;
    logic        last_grp;
  } group_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  localparam logic [15:0] CrcTagBounce = crc_byte(CrcInit, TagBounce);
  localparam logic [15:0] CrcTagPlain  = crc_byte(CrcInit, TagPlain);

  function automatic logic [6:0] b64url_char(input logic [5:0] s);
    logic [6:0] c;
    if (s < 6'd26) begin
      c = CharUpA + {1'b0, s};
    end else if (s < 6'd52) begin
      c = CharLowA + {1'b0, s - 6'd26};
    end else if (s < 6'd62) begin
      c = CharZero + {1'b0, s - 6'd52};
    end else if (s == 6'd62) begin
      c = CharMinus;
    end else begin
      c = CharUnder;
    end
    return c;
  endfunction

endpackage

// ----- design/cab64_if.sv -----
// ----------------------------------------------------------------------------
// cab64 channel interfaces
// Valid/ready channels for address bytes in and text characters out.
// ----------------------------------------------------------------------------
interface cab64_in_if;
  logic              valid;
  logic              ready;
  logic [7:0]        address_byte;
  logic signed [7:0] chain_number;
  logic              bounceable;

  modport source (output valid, output address_byte, output chain_number,
                  output bounceable, input ready);
  modport sink   (input valid, input address_byte, input chain_number,
                  input bounceable, output ready);
endinterface

interface cab64_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       last_char;

  modport source (output valid, output out_char, output last_char, input ready);
  modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

// ----- design/checksummed_address_base64url_encoder.sv -----
// ----------------------------------------------------------------------------
// checksummed_address_base64url_encoder
// The byte that completes a group is written into the queue; the back end
// then loads the group's first character into the output register.
// Throughput: one character per cycle at the output register while the output
// is ready; 48 characters per 32 bytes, so the output port sets the rate.
// Reset clears the byte position, crc, queue and output valid at once.
// ----------------------------------------------------------------------------
module checksummed_address_base64url_encoder (
  input  logic         clk_i,
  input  logic         rst_ni,
  cab64_in_if.sink     in_i,
  cab64_out_if.source  out_o
);

  cab64_pkg::group_t  push;
  logic               push_valid;
  cab64_pkg::group_t  head;
  cab64_pkg::q_stat_t q_stat;
  logic               pop;

  cab64_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .q_stat_i     (q_stat),
    .push_o       (push),
    .push_valid_o (push_valid)
  );

  cab64_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_valid_i (push_valid),
    .pop_i        (pop),
    .head_o       (head),
    .stat_o       (q_stat)
  );

  cab64_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .out_o    (out_o)
  );

  a_no_push_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid |-> (!q_stat.full || pop))
    else $error("group written into a full queue");

  a_no_pop_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("group taken from an empty queue");

  a_pop_with_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> (out_o.valid && !q_stat.full))
    else $error("group retired without its last character loaded");

endmodule

// ----- design/cab64_front.sv -----
// ----------------------------------------------------------------------------
// cab64_front
// Accepts address bytes, runs the crc and packs frame bytes into groups of three.
// ----------------------------------------------------------------------------
module cab64_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  cab64_in_if.sink            in_i,
  input  cab64_pkg::q_stat_t  q_stat_i,
  output cab64_pkg::group_t   push_o,
  output logic                push_valid_o
);

  logic [cab64_pkg::IdxW-1:0] idx_q, idx_d;
  logic [15:0]                crc_q, crc_d;
  logic [15:0]                pend_q, pend_d;
  logic [1:0]                 cnt_q, cnt_d;

  logic        emits;
  logic        fire;
  logic [15:0] crc_base;
  logic [15:0] crc_new;
  logic [7:0]  tag;
  logic [7:0]  chain;

  assign emits = (idx_q == cab64_pkg::FirstIdx) || (idx_q == cab64_pkg::LastIdx) ||
                 (cnt_q == cab64_pkg::PendFull);
  assign in_i.ready = !q_stat_i.full || !emits;
  assign fire = in_i.valid && in_i.ready;

  assign tag   = in_i.bounceable ? cab64_pkg::TagBounce : cab64_pkg::TagPlain;
  assign chain = in_i.chain_number;

  always_comb begin
    if (idx_q == cab64_pkg::FirstIdx) begin
      crc_base = cab64_pkg::crc_byte(in_i.bounceable ? cab64_pkg::CrcTagBounce
                                                     : cab64_pkg::CrcTagPlain, chain);
    end else begin
      crc_base = crc_q;
    end
    crc_new = cab64_pkg::crc_byte(crc_base, in_i.address_byte);
  end

  always_comb begin
    idx_d           = idx_q;
    crc_d           = crc_q;
    pend_d          = pend_q;
    cnt_d           = cnt_q;
    push_o.word     = {pend_q, in_i.address_byte};
    push_o.last_grp = 1'b0;
    push_valid_o    = fire && emits;
    if (idx_q == cab64_pkg::LastIdx) begin
      push_o.word     = {in_i.address_byte, crc_new};
      push_o.last_grp = 1'b1;
    end else if (idx_q == cab64_pkg::FirstIdx) begin
      push_o.word = {tag, chain, in_i.address_byte};
    end
    if (fire) begin
      crc_d = crc_new;
      idx_d = idx_q + 1'b1;
      if (emits) begin
        pend_d = '0;
        cnt_d  = '0;
      end else begin
        pend_d = {pend_q[7:0], in_i.address_byte};
        cnt_d  = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      crc_q  <= cab64_pkg::CrcInit;
      pend_q <= '0;
      cnt_q  <= '0;
    end else begin
      idx_q  <= idx_d;
      crc_q  <= crc_d;
      pend_q <= pend_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ----- design/cab64_queue.sv -----
// ----------------------------------------------------------------------------
// cab64_queue
// Short first-in first-out store of byte groups between front and back.
// ----------------------------------------------------------------------------
module cab64_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cab64_pkg::group_t   push_i,
  input  logic                push_valid_i,
  input  logic                pop_i,
  output cab64_pkg::group_t   head_o,
  output cab64_pkg::q_stat_t  stat_o
);

  cab64_pkg::group_t mem_q [cab64_pkg::QDepth];

  logic [cab64_pkg::QPtrW-1:0] wr_q, wr_d;
  logic [cab64_pkg::QPtrW-1:0] rd_q, rd_d;
  logic [cab64_pkg::QCntW-1:0] cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == cab64_pkg::QCntW'(cab64_pkg::QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign head_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_valid_i) begin
      wr_d = (wr_q == cab64_pkg::QPtrW'(cab64_pkg::QDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == cab64_pkg::QPtrW'(cab64_pkg::QDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_valid_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_valid_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_valid_i) begin
      mem_q[wr_q] <= push_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- design/cab64_back.sv -----
// ----------------------------------------------------------------------------
// cab64_back
// Turns each byte group into four base64url characters, one per cycle while the output is ready.
// ----------------------------------------------------------------------------
module cab64_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cab64_pkg::group_t   head_i,
  input  cab64_pkg::q_stat_t  q_stat_i,
  output logic                pop_o,
  cab64_out_if.source         out_o
);

  logic [1:0] k_q, k_d;
  logic       ov_q, ov_d;
  logic [6:0] ch_q, ch_d;
  logic       lc_q, lc_d;
  logic       advance;
  logic [5:0] sext;

  assign advance = !ov_q || out_o.ready;

  always_comb begin
    case (k_q)
      2'd0:    sext = head_i.word[23:18];
      2'd1:    sext = head_i.word[17:12];
      2'd2:    sext = head_i.word[11:6];
      default: sext = head_i.word[5:0];
    endcase
  end

  always_comb begin
    k_d   = k_q;
    ov_d  = ov_q;
    ch_d  = ch_q;
    lc_d  = lc_q;
    pop_o = 1'b0;
    if (advance) begin
      ov_d = !q_stat_i.empty;
      if (!q_stat_i.empty) begin
        ch_d  = cab64_pkg::b64url_char(sext);
        lc_d  = head_i.last_grp && (k_q == cab64_pkg::SextLast);
        k_d   = k_q + 1'b1;
        pop_o = (k_q == cab64_pkg::SextLast);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q  <= '0;
      ov_q <= 1'b0;
    end else begin
      k_q  <= k_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q <= ch_d;
    lc_q <= lc_d;
  end

  assign out_o.valid     = ov_q;
  assign out_o.out_char  = ch_q;
  assign out_o.last_char = lc_q;

endmodule
